FILE: rtl/wrs_pkg.sv
// Shared types and constants for the window region selector.
// No dependencies.
`timescale 1ns / 1ps
package wrs_pkg;
  // The region index leaves on the four-bit region_index port, so the region table size is fixed.
  localparam int MAX_REGIONS = 16;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD_REGION = 2'd1;
  localparam logic [1:0] FUNC_ADD_RECT = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [1:0] REG_HALF_X = 2'd0;
  localparam logic [1:0] REG_HALF_Y = 2'd1;
  localparam logic [1:0] REG_CONTEXT = 2'd2;
  localparam logic [1:0] REG_RAFT = 2'd3;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } box_t;
endpackage

FILE: rtl/wrs_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module wrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/window_region_selector.sv
// Top level of the window region selector: control sequencer, region and
// rectangle memories, candidate evaluation. Uses wrs_pkg and wrs_ram.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-------------------------------------
//   request   | start / busy        | func, lo/hi_x/y, explicit_centers,
//             |                     | pos_x/y, active_region, use_required
//   result    | done (strobe)       | status, region_index, center_x/y
//   config    | cfg_we              | cfg_index, cfg_data
//
// Clear, add region and add rectangle pass the region read, region data and
// finish states; done is registered in the finish state. A query walks every
// stored region (none if the required box is empty), then for each explicit
// region every stored rectangle, one memory read per entry; each candidate
// passes a five-stage evaluation (clamp, checks, squares, sum, compare). Busy
// is low during the done cycle, so the next request can be accepted at the
// edge that ends it.
// Reset is synchronous and clears the counts, the registers to their
// defaults and the control state; memory contents are left undefined.
// The result receiver cannot stall: done is high for one cycle.
`timescale 1ns / 1ps
module window_region_selector
  import wrs_pkg::*;
#(
  parameter int MAX_CENTER_RECTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] lo_x,
  input  logic signed [31:0] lo_y,
  input  logic signed [31:0] hi_x,
  input  logic signed [31:0] hi_y,
  input  logic               explicit_centers,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [4:0]         active_region,
  input  logic               use_required,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [29:0]        cfg_data,
  output logic               done,
  output logic [1:0]         status,
  output logic [3:0]         region_index,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y
);
  localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int KW = (MAX_CENTER_RECTS > 1) ? $clog2(MAX_CENTER_RECTS) : 1;
  localparam int RCW = $clog2(MAX_REGIONS + 1);
  localparam int KCW = $clog2(MAX_CENTER_RECTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RREAD = 3'd1;  // region read issued
  localparam logic [2:0] S_RDATA = 3'd2;  // region data available
  localparam logic [2:0] S_KDATA = 3'd3;  // rectangle data available
  localparam logic [2:0] S_EVAL = 3'd4;   // candidate in evaluation
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [29:0] half_x, half_y, ctx_m, raft_m;
  logic [RCW-1:0] region_count;
  logic [KCW-1:0] rect_count;

  logic [2:0] state;
  logic [1:0] q_func;
  box_t q_box;
  logic q_expl, q_req;
  logic signed [31:0] q_px, q_py;
  logic [4:0] q_act;

  // Wide working values.
  logic signed [33:0] hx, hy;      // half extent plus context
  assign hx = $signed({4'b0, half_x}) + $signed({4'b0, ctx_m});
  assign hy = $signed({4'b0, half_y}) + $signed({4'b0, ctx_m});

  // Memories.
  logic            rg_we;
  logic [RW-1:0]   rg_waddr, rg_raddr;
  logic [128:0]    rg_rdata;
  logic            rc_we;
  logic [KW-1:0]   rc_waddr, rc_raddr;
  logic [128+RW-1:0] rc_rdata;

  wrs_ram #(.WIDTH(129), .DEPTH(MAX_REGIONS)) u_regions (
    .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata({q_expl, q_box}),
    .raddr(rg_raddr), .rdata(rg_rdata)
  );
  wrs_ram #(.WIDTH(128 + RW), .DEPTH(MAX_CENTER_RECTS)) u_rects (
    .clk(clk), .we(rc_we), .waddr(rc_waddr),
    .wdata({rg_waddr, q_box}), .raddr(rc_raddr), .rdata(rc_rdata)
  );

  box_t   g;             // current region box
  logic [RW-1:0] r_idx;
  logic [RCW-1:0] r_cnt;
  logic [KCW-1:0] k_cnt;

  // Best candidate.
  logic best_valid, best_active;
  logic [64:0] best_shift;
  logic signed [33:0] best_margin;
  logic signed [31:0] best_cx, best_cy;
  logic [RW-1:0] best_index;

  // Candidate pipeline: stage A holds rectangle; evaluation computes from it in the following cycle.
  box_t c_rect;
  logic c_clip;          // intersect with required box
  logic signed [33:0] rq_x0, rq_y0, rq_x1, rq_y1;
  assign rq_x0 = 34'(q_box.x1) - $signed({4'b0, half_x});
  assign rq_y0 = 34'(q_box.y1) - $signed({4'b0, half_y});
  assign rq_x1 = 34'(q_box.x0) + $signed({4'b0, half_x});
  assign rq_y1 = 34'(q_box.y0) + $signed({4'b0, half_y});

  // Eval stage 1: intersect and clamp.
  logic signed [34:0] ix0, iy0, ix1, iy1, cxw, cyw;
  logic e1_ok;
  always_comb begin
    ix0 = 35'(c_rect.x0); iy0 = 35'(c_rect.y0);
    ix1 = 35'(c_rect.x1); iy1 = 35'(c_rect.y1);
    if (c_clip) begin
      if (35'(rq_x0) > ix0) ix0 = 35'(rq_x0);
      if (35'(rq_y0) > iy0) iy0 = 35'(rq_y0);
      if (35'(rq_x1) < ix1) ix1 = 35'(rq_x1);
      if (35'(rq_y1) < iy1) iy1 = 35'(rq_y1);
    end
    e1_ok = (ix0 <= ix1) && (iy0 <= iy1);
    cxw = (35'(q_px) < ix0) ? ix0 : ((35'(q_px) < ix1) ? 35'(q_px) : ix1);
    cyw = (35'(q_py) < iy0) ? iy0 : ((35'(q_py) < iy1) ? 35'(q_py) : iy1);
  end

  logic [2:0] ev;        // evaluation stage counter
  logic e_ok;
  logic signed [34:0] e_cx, e_cy;
  logic signed [35:0] e_dx, e_dy;
  logic signed [35:0] lx, ly;
  assign lx = $signed({6'b0, half_x}) - $signed({6'b0, raft_m});
  assign ly = $signed({6'b0, half_y}) - $signed({6'b0, raft_m});
  logic [35:0] adx, ady;
  assign adx = e_dx[35] ? 36'(-e_dx) : 36'(e_dx);
  assign ady = e_dy[35] ? 36'(-e_dy) : 36'(e_dy);
  logic fit_ok;
  assign fit_ok = !($signed(adx) > lx || $signed(ady) > ly)
      && !(36'(e_cx) - 36'(hx) < 36'(g.x0) || 36'(e_cy) - 36'(hy) < 36'(g.y0))
      && !(36'(e_cx) + 36'(hx) > 36'(g.x1) || 36'(e_cy) + 36'(hy) > 36'(g.y1));
  logic signed [35:0] m0, m1, m2, m3, mm;
  always_comb begin
    m0 = 36'(e_cx) - 36'(g.x0);
    m1 = 36'(e_cy) - 36'(g.y0);
    m2 = 36'(g.x1) - 36'(e_cx);
    m3 = 36'(g.y1) - 36'(e_cy);
    mm = m0;
    if (m1 < mm) mm = m1;
    if (m2 < mm) mm = m2;
    if (m3 < mm) mm = m3;
  end
  // Inside a kept candidate the offsets fit in 31 bits; squares in 62.
  logic [63:0] sqx, sqy;
  logic [64:0] e_shift;
  logic signed [33:0] e_margin;
  logic e_act;
  logic take;
  always_comb begin
    if (!best_valid || e_shift < best_shift) take = 1'b1;
    else if (e_shift == best_shift)
      take = (e_act && !best_active) ||
             (e_act == best_active && e_margin > best_margin);
    else take = 1'b0;
  end

  logic k_scan;          // scanning rectangles for current region

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_x <= 30'd50000; half_y <= 30'd50000;
      ctx_m <= 30'd3000; raft_m <= 30'd0;
      region_count <= '0; rect_count <= '0;
      state <= S_IDLE; done <= 1'b0;
      rg_we <= 1'b0; rc_we <= 1'b0; ev <= '0;
    end else begin
      done <= 1'b0;
      rg_we <= 1'b0; rc_we <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_X: half_x <= cfg_data;
          REG_HALF_Y: half_y <= cfg_data;
          REG_CONTEXT: ctx_m <= cfg_data;
          REG_RAFT: raft_m <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            q_func <= func; q_box <= '{lo_x, lo_y, hi_x, hi_y};
            q_expl <= explicit_centers; q_req <= use_required;
            q_px <= pos_x; q_py <= pos_y; q_act <= active_region;
            best_valid <= 1'b0; best_active <= 1'b0; best_shift <= '0;
            best_margin <= -34'sd1; best_cx <= '0; best_cy <= '0;
            best_index <= '0; r_cnt <= '0; k_scan <= 1'b0;
            if (func == FUNC_QUERY) rg_raddr <= '0;
            else rg_raddr <= RW'(region_count - RCW'(1));
            state <= S_RREAD;
          end
        end
        S_RREAD: state <= S_RDATA;
        S_RDATA: begin
          g <= rg_rdata[127:0];
          case (q_func)
            FUNC_CLEAR: begin
              region_count <= '0; rect_count <= '0;
              status <= ST_OK; state <= S_FINISH;
            end
            FUNC_ADD_REGION: begin
              if (36'(q_box.x1) - 36'(q_box.x0) < 36'(hx) * 2 ||
                  36'(q_box.y1) - 36'(q_box.y0) < 36'(hy) * 2)
                status <= ST_INVALID;
              else if (region_count >= RCW'(MAX_REGIONS)) status <= ST_FULL;
              else begin
                status <= ST_OK; rg_we <= 1'b1;
                rg_waddr <= RW'(region_count);
                region_count <= region_count + RCW'(1);
              end
              state <= S_FINISH;
            end
            FUNC_ADD_RECT: begin
              if (region_count == '0 || !rg_rdata[128]) status <= ST_INVALID;
              else if (q_box.x0 > q_box.x1 || q_box.y0 > q_box.y1 ||
                  36'(q_box.x0) - 36'(hx) < 36'($signed(rg_rdata[127:96])) ||
                  36'(q_box.y0) - 36'(hy) < 36'($signed(rg_rdata[95:64])) ||
                  36'(q_box.x1) + 36'(hx) > 36'($signed(rg_rdata[63:32])) ||
                  36'(q_box.y1) + 36'(hy) > 36'($signed(rg_rdata[31:0])))
                status <= ST_INVALID;
              else if (rect_count >= KCW'(MAX_CENTER_RECTS)) status <= ST_FULL;
              else begin
                status <= ST_OK; rc_we <= 1'b1;
                rc_waddr <= KW'(rect_count);
                rg_waddr <= RW'(region_count - RCW'(1));
                rect_count <= rect_count + KCW'(1);
              end
              state <= S_FINISH;
            end
            default: begin
              r_idx <= RW'(r_cnt);
              if ((q_req && (rq_x0 > rq_x1 || rq_y0 > rq_y1)) ||
                  r_cnt >= region_count) begin
                state <= S_FINISH;
              end else if (rg_rdata[128]) begin
                k_cnt <= '0; rc_raddr <= '0;
                state <= S_KDATA; k_scan <= 1'b0;
              end else begin
                if (q_req)
                  c_rect <= '{32'(rg_rdata[127:96] + 32'(hx)),
                              32'(rg_rdata[95:64] + 32'(hy)),
                              32'(rg_rdata[63:32] - 32'(hx)),
                              32'(rg_rdata[31:0] - 32'(hy))};
                else c_rect <= '{q_px, q_py, q_px, q_py};
                // A stored region is at least 2*hx wide, so the shrunken box
                // always fits in 32 bits.
                c_clip <= q_req; ev <= '0; k_scan <= 1'b0;
                state <= S_EVAL;
              end
            end
          endcase
        end
        S_KDATA: begin
          // rc_rdata valid in the cycle after rc_raddr is set
          if (!k_scan) begin
            k_scan <= 1'b1;
          end else if (k_cnt >= rect_count) begin
            r_cnt <= r_cnt + RCW'(1);
            rg_raddr <= RW'(r_cnt + RCW'(1));
            state <= S_RREAD;
          end else if (rc_rdata[128+RW-1:128] == r_idx) begin
            c_rect <= rc_rdata[127:0]; c_clip <= q_req; ev <= '0;
            state <= S_EVAL;
          end else begin
            k_cnt <= k_cnt + KCW'(1);
            rc_raddr <= KW'(k_cnt + KCW'(1));
            k_scan <= 1'b0;
          end
        end
        S_EVAL: begin
          ev <= ev + 3'd1;
          case (ev)
            3'd0: begin
              e_ok <= e1_ok; e_cx <= cxw; e_cy <= cyw;
              e_dx <= 36'(q_px) - 36'(cxw); e_dy <= 36'(q_py) - 36'(cyw);
            end
            3'd1: begin
              e_ok <= e_ok && fit_ok; e_margin <= 34'(mm);
              e_act <= ({{(5 > RW ? 5 - RW : 0){1'b0}}, r_idx} == q_act);
            end
            3'd2: begin
              sqx <= 64'(adx[31:0]) * 64'(adx[31:0]);
              sqy <= 64'(ady[31:0]) * 64'(ady[31:0]);
            end
            3'd3: e_shift <= 65'(sqx) + 65'(sqy);
            default: begin
              if (e_ok && take) begin
                best_valid <= 1'b1; best_shift <= e_shift;
                best_margin <= e_margin; best_active <= e_act;
                best_cx <= 32'(e_cx); best_cy <= 32'(e_cy);
                best_index <= r_idx;
              end
              if (k_scan) begin
                k_cnt <= k_cnt + KCW'(1);
                rc_raddr <= KW'(k_cnt + KCW'(1));
                k_scan <= 1'b0;
                state <= S_KDATA;
              end else begin
                r_cnt <= r_cnt + RCW'(1);
                rg_raddr <= RW'(r_cnt + RCW'(1));
                state <= S_RREAD;
              end
            end
          endcase
        end
        S_FINISH: begin
          done <= 1'b1;
          if (q_func == FUNC_QUERY) begin
            status <= best_valid ? ST_OK : ST_NONE;
            region_index <= best_valid ? 4'(best_index) : 4'd0;
            center_x <= best_valid ? best_cx : 32'sd0;
            center_y <= best_valid ? best_cy : 32'sd0;
          end else begin
            region_index <= '0; center_x <= '0; center_y <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: dv/testbench.sv
// Self-checking bench for window_region_selector: builds region tables, queries
// them under random start gaps and checks each result against a local predictor.
// Depends on wrs_pkg and the window_region_selector RTL.
`timescale 1ns / 1ps
module testbench;
  import wrs_pkg::*;

  localparam int NREG = 16;
  localparam int NRECT = 64;
  localparam longint CYCLE_LIMIT = 64'd30000000;

  // One request as the driver presents it.
  typedef struct {
    logic [1:0] fn;
    logic signed [31:0] lx, ly, hx, hy;
    logic ex;
    logic signed [31:0] px, py;
    logic [4:0] act;
    logic req;
  } request_t;

  // One expected selector answer.
  typedef struct {
    logic [1:0] st;
    logic [3:0] idx;
    logic signed [31:0] cx, cy;
  } answer_t;

  typedef struct {
    longint x0, y0, x1, y1;
  } lbox_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = FUNC_CLEAR;
  logic signed [31:0] lo_x = '0, lo_y = '0, hi_x = '0, hi_y = '0;
  logic explicit_centers = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0;
  logic [4:0] active_region = '0;
  logic use_required = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_HALF_X;
  logic [29:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [3:0] region_index;
  logic signed [31:0] center_x, center_y;

  window_region_selector i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .lo_x(lo_x), .lo_y(lo_y), .hi_x(hi_x), .hi_y(hi_y),
    .explicit_centers(explicit_centers), .pos_x(pos_x), .pos_y(pos_y),
    .active_region(active_region), .use_required(use_required),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .region_index(region_index),
    .center_x(center_x), .center_y(center_y)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predictor copy of the block's state and configuration.
  longint half_x, half_y, ctx_w, raft_w;
  lbox_t regions[NREG];
  bit region_expl[NREG];
  lbox_t rects[NRECT];
  int rect_region[NRECT];
  int n_regions, n_rects;

  // Running best candidate of a query.
  longint q_px, q_py, q_hx, q_hy;
  bit best_ok, best_act;
  longint best_shift, best_edge, best_cx, best_cy;
  int best_reg;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  longint cycles = 0;

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint labs(longint a);
    return a < 0 ? -a : a;
  endfunction

  // Scores one candidate center of region r against the current best.
  function automatic void score_center(int r, longint cx, longint cy, int act);
    longint dx, dy, sh, edge_m;
    bit is_act, take;
    dx = q_px - cx;
    dy = q_py - cy;
    if (labs(dx) > half_x - raft_w || labs(dy) > half_y - raft_w) return;
    if (cx - q_hx < regions[r].x0 || cy - q_hy < regions[r].y0) return;
    if (cx + q_hx > regions[r].x1 || cy + q_hy > regions[r].y1) return;
    sh = dx * dx + dy * dy;
    is_act = (r == act);
    edge_m = lmin(lmin(cx - regions[r].x0, cy - regions[r].y0),
                  lmin(regions[r].x1 - cx, regions[r].y1 - cy));
    if (!best_ok || sh < best_shift) take = 1;
    else if (sh == best_shift)
      take = (is_act && !best_act) || (is_act == best_act && edge_m > best_edge);
    else take = 0;
    if (take) begin
      best_ok = 1; best_shift = sh; best_edge = edge_m; best_act = is_act;
      best_cx = cx; best_cy = cy; best_reg = r;
    end
  endfunction

  // Clamps the position into a rectangle, optionally cut by the required box.
  function automatic void clamp_into(int r, lbox_t c, bit req, lbox_t rq, int act);
    longint cx, cy;
    if (req) begin
      if (rq.x0 > c.x0) c.x0 = rq.x0;
      if (rq.y0 > c.y0) c.y0 = rq.y0;
      if (rq.x1 < c.x1) c.x1 = rq.x1;
      if (rq.y1 < c.y1) c.y1 = rq.y1;
    end
    if (c.x0 <= c.x1 && c.y0 <= c.y1) begin
      cx = q_px < c.x0 ? c.x0 : (q_px < c.x1 ? q_px : c.x1);
      cy = q_py < c.y0 ? c.y0 : (q_py < c.y1 ? q_py : c.y1);
      score_center(r, cx, cy, act);
    end
  endfunction

  // Applies one request to the predictor state and returns the answer.
  function automatic answer_t predict_selection(request_t q);
    answer_t a;
    lbox_t b, g, rq, full;
    b.x0 = q.lx; b.y0 = q.ly; b.x1 = q.hx; b.y1 = q.hy;
    a.st = ST_OK; a.idx = '0; a.cx = '0; a.cy = '0;
    q_hx = half_x + ctx_w;
    q_hy = half_y + ctx_w;
    case (q.fn)
      FUNC_CLEAR: begin
        n_regions = 0; n_rects = 0;
      end
      FUNC_ADD_REGION: begin
        if (b.x1 - b.x0 < 2 * q_hx || b.y1 - b.y0 < 2 * q_hy) a.st = ST_INVALID;
        else if (n_regions >= NREG) a.st = ST_FULL;
        else begin
          regions[n_regions] = b;
          region_expl[n_regions] = q.ex;
          n_regions++;
        end
      end
      FUNC_ADD_RECT: begin
        if (n_regions == 0 || !region_expl[n_regions - 1]) a.st = ST_INVALID;
        else begin
          g = regions[n_regions - 1];
          if (b.x0 > b.x1 || b.y0 > b.y1 || b.x0 - q_hx < g.x0 || b.y0 - q_hy < g.y0
              || b.x1 + q_hx > g.x1 || b.y1 + q_hy > g.y1) a.st = ST_INVALID;
          else if (n_rects >= NRECT) a.st = ST_FULL;
          else begin
            rects[n_rects] = b;
            rect_region[n_rects] = n_regions - 1;
            n_rects++;
          end
        end
      end
      default: begin
        q_px = q.px; q_py = q.py;
        best_ok = 0; best_act = 0; best_shift = 0; best_edge = -1;
        best_cx = 0; best_cy = 0; best_reg = 0;
        rq.x0 = b.x1 - half_x; rq.y0 = b.y1 - half_y;
        rq.x1 = b.x0 + half_x; rq.y1 = b.y0 + half_y;
        if (!(q.req && (rq.x0 > rq.x1 || rq.y0 > rq.y1))) begin
          for (int r = 0; r < n_regions; r++) begin
            if (region_expl[r]) begin
              for (int k = 0; k < n_rects; k++)
                if (rect_region[k] == r) clamp_into(r, rects[k], q.req, rq, q.act);
            end else if (q.req) begin
              full.x0 = regions[r].x0 + q_hx; full.y0 = regions[r].y0 + q_hy;
              full.x1 = regions[r].x1 - q_hx; full.y1 = regions[r].y1 - q_hy;
              clamp_into(r, full, 1'b1, rq, q.act);
            end else begin
              score_center(r, q_px, q_py, q.act);
            end
          end
        end
        if (best_ok) begin
          a.idx = best_reg[3:0]; a.cx = best_cx[31:0]; a.cy = best_cy[31:0];
        end else a.st = ST_NONE;
      end
    endcase
    return a;
  endfunction

  function automatic request_t blank_request(logic [1:0] fn);
    request_t q;
    q.fn = fn;
    q.lx = $urandom; q.ly = $urandom; q.hx = $urandom; q.hy = $urandom;
    q.ex = $urandom_range(0, 1);
    q.px = $urandom; q.py = $urandom;
    q.act = $urandom_range(0, 31);
    q.req = $urandom_range(0, 1);
    return q;
  endfunction

  // A random coordinate within 200000 of the origin, occasionally anywhere.
  function automatic longint rand_coord();
    case ($urandom_range(0, 9))
      0: return $signed(32'($urandom));
      default: return longint'($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  // A region roughly the size of the window, explicit or not.
  function automatic request_t region_request(bit ex);
    request_t q;
    longint cx, cy, wx, wy;
    q = blank_request(FUNC_ADD_REGION);
    cx = rand_coord();
    cy = rand_coord();
    wx = (half_x + ctx_w) + $urandom_range(0, 60000) - ($urandom_range(0, 7) == 0 ? 5 : 0);
    wy = (half_y + ctx_w) + $urandom_range(0, 60000);
    q.lx = cx - wx; q.hx = cx + wx; q.ly = cy - wy; q.hy = cy + wy;
    q.ex = ex;
    return q;
  endfunction

  // A center rectangle inside the most recent region (sometimes broken).
  function automatic request_t rect_request(lbox_t g);
    request_t q;
    longint ax, bx, ay, by, t;
    q = blank_request(FUNC_ADD_RECT);
    ax = g.x0 + half_x + ctx_w; bx = g.x1 - half_x - ctx_w;
    ay = g.y0 + half_y + ctx_w; by = g.y1 - half_y - ctx_w;
    if (ax > bx) begin t = ax; ax = bx; bx = t; end
    if (ay > by) begin t = ay; ay = by; by = t; end
    q.lx = ax + $urandom_range(0, 32'(bx - ax));
    q.hx = q.lx + $urandom_range(0, 32'(bx - q.lx));
    q.ly = ay + $urandom_range(0, 32'(by - ay));
    q.hy = q.ly + $urandom_range(0, 32'(by - q.ly));
    if ($urandom_range(0, 9) == 0) q.hx = q.lx - 1;
    if ($urandom_range(0, 9) == 0) q.hy = q.hy + 100000;
    return q;
  endfunction

  // A query near the stored regions, sometimes with a required box.
  function automatic request_t query_request();
    request_t q;
    int r;
    q = blank_request(FUNC_QUERY);
    q.act = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 17));
    if (n_regions > 0 && $urandom_range(0, 7) != 0) begin
      r = $urandom_range(0, n_regions - 1);
      q.px = (regions[r].x0 + regions[r].x1) / 2 + longint'($urandom_range(0, 160000)) - 80000;
      q.py = (regions[r].y0 + regions[r].y1) / 2 + longint'($urandom_range(0, 160000)) - 80000;
      q.lx = q.px - $urandom_range(0, 40000); q.hx = q.px + $urandom_range(0, 40000);
      q.ly = q.py - $urandom_range(0, 40000); q.hy = q.py + $urandom_range(0, 40000);
      if ($urandom_range(0, 5) == 0) q.hx = q.lx + 3 * half_x;
    end
    return q;
  endfunction

  // Driver: presents queued requests at the falling edge, with bursts and gaps.
  int gap_left = 0;
  int burst_left = 0;

  // The request is accepted at a rising edge with start high and busy low; the
  // predictor runs at that edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_answers.push_back(predict_selection(pending_requests.pop_front()));
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        start <= 1'b0;
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
          func <= pending_requests[0].fn;
          lo_x <= pending_requests[0].lx; lo_y <= pending_requests[0].ly;
          hi_x <= pending_requests[0].hx; hi_y <= pending_requests[0].hy;
          explicit_centers <= pending_requests[0].ex;
          pos_x <= pending_requests[0].px; pos_y <= pending_requests[0].py;
          active_region <= pending_requests[0].act;
          use_required <= pending_requests[0].req;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks each strobed result against the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result status=%0d", status);
      end else begin
        e = expected_answers.pop_front();
        if (status !== e.st || region_index !== e.idx || center_x !== e.cx
            || center_y !== e.cy) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: exp st=%0d idx=%0d c=(%0d,%0d) got st=%0d idx=%0d c=(%0d,%0d)",
                     e.st, e.idx, e.cx, e.cy, status, region_index, center_x, center_y);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Waits until every queued request is accepted and answered, then idles.
  task automatic drain_all();
    while (pending_requests.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes one register while the block is idle; mirrors it in the predictor.
  task automatic write_register(logic [1:0] idx, logic [29:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HALF_X: half_x = val;
      REG_HALF_Y: half_y = val;
      REG_CONTEXT: ctx_w = val;
      default: raft_w = val;
    endcase
  endtask

  // Fills the queue with one random phase: table building mixed with queries.
  // Items are queued in groups of eight from the table as it stands after the
  // previous group has been answered.
  task automatic random_phase(int items);
    int produced;
    request_t q;
    produced = 0;
    pending_requests.push_back(blank_request(FUNC_CLEAR));
    n_regions = 0; n_rects = 0;
    while (produced < items) begin
      if (produced % 8 == 0) drain_all();
      case ($urandom_range(0, 19))
        0: q = blank_request(FUNC_CLEAR);
        1, 2: q = blank_request($urandom_range(0, 3));
        3, 4, 5: q = region_request($urandom_range(0, 1));
        6, 7, 8: begin
          if (n_regions > 0) q = rect_request(regions[n_regions - 1]);
          else q = region_request(1'b1);
        end
        default: q = query_request();
      endcase
      pending_requests.push_back(q);
      produced++;
    end
    drain_all();
  endtask

  initial begin
    request_t q;
    half_x = 50000; half_y = 50000; ctx_w = 3000; raft_w = 0;
    n_regions = 0; n_rects = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty query, too-small region, rectangle with no explicit
    // region, full region table, required box with no centers, ties.
    pending_requests.push_back(blank_request(FUNC_QUERY));
    q = blank_request(FUNC_ADD_REGION);
    q.lx = 32'sh80000000; q.ly = 32'sh80000000; q.hx = 32'sh7fffffff; q.hy = 32'sh7fffffff;
    q.ex = 1'b0;
    pending_requests.push_back(q);
    q = blank_request(FUNC_ADD_RECT);
    q.lx = 0; q.ly = 0; q.hx = 0; q.hy = 0;
    pending_requests.push_back(q);
    q = blank_request(FUNC_ADD_REGION);
    q.lx = 0; q.ly = 0; q.hx = 1000; q.hy = 1000000;
    pending_requests.push_back(q);
    q = blank_request(FUNC_QUERY);
    q.px = 32'sh7fffffff; q.py = 32'sh80000000; q.req = 1'b0; q.act = 5'd0;
    pending_requests.push_back(q);
    q.px = 0; q.py = 0; q.req = 1'b1;
    q.lx = -1000; q.hx = 1000; q.ly = -200000; q.hy = 200000;
    pending_requests.push_back(q);
    q = blank_request(FUNC_ADD_REGION);
    q.lx = -300000; q.ly = -300000; q.hx = 300000; q.hy = 300000; q.ex = 1'b1;
    pending_requests.push_back(q);
    for (int i = 0; i < 3; i++) begin
      q = blank_request(FUNC_ADD_RECT);
      q.lx = -100000 + i * 50000; q.ly = -10000; q.hx = q.lx + 20000; q.hy = 10000;
      pending_requests.push_back(q);
    end
    q = blank_request(FUNC_QUERY);
    q.px = 5000; q.py = 0; q.req = 1'b0; q.act = 5'd1;
    pending_requests.push_back(q);
    q = blank_request(FUNC_ADD_REGION);
    q.lx = -300000; q.ly = -300000; q.hx = 300000; q.hy = 300000; q.ex = 1'b0;
    for (int i = 0; i < 16; i++) pending_requests.push_back(q);
    q = blank_request(FUNC_QUERY);
    q.px = 0; q.py = 0; q.req = 1'b0; q.act = 5'd16;
    pending_requests.push_back(q);
    // Pause here so every directed answer is in before the random phases.
    drain_all();

    random_phase(500);

    write_register(REG_HALF_X, 30'd1);
    write_register(REG_HALF_Y, 30'd1);
    write_register(REG_CONTEXT, 30'd0);
    write_register(REG_RAFT, 30'd0);
    random_phase(300);

    write_register(REG_HALF_X, 30'd20000);
    write_register(REG_HALF_Y, 30'd35000);
    write_register(REG_CONTEXT, 30'd1500);
    write_register(REG_RAFT, 30'd5000);
    random_phase(600);

    write_register(REG_RAFT, 30'd40000);
    random_phase(200);

    write_register(REG_HALF_X, 30'h3fffffff);
    write_register(REG_HALF_Y, 30'h3fffffff);
    write_register(REG_CONTEXT, 30'h3fffffff);
    write_register(REG_RAFT, 30'h3fffffff);
    random_phase(100);

    write_register(REG_HALF_X, 30'd50000);
    write_register(REG_HALF_Y, 30'd50000);
    write_register(REG_CONTEXT, 30'd3000);
    write_register(REG_RAFT, 30'd0);
    random_phase(400);

    drain_all();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
